FILE: src/bba_pkg.sv
package bba_pkg;

  // Largest map the block can manage; the map storage follows from it.
  localparam int MAX_BLOCKS = 1024;
  localparam int MAP_BYTES  = (MAX_BLOCKS + 7) / 8;
  localparam int BYTE_W     = $clog2(MAP_BYTES);
  localparam int NBYTE_W    = BYTE_W + 1;

  // Field widths of the stream items and the register
  localparam int MODE_W = 3;
  localparam int BLK_W  = 10;
  localparam int LEN_W  = 11;
  localparam int STAT_W = 2;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 16;

  // Configuration port
  localparam int                  CFG_ADDR_W        = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCKS_IN_USE = CFG_ADDR_W'(0);
  localparam logic [LEN_W-1:0]    BLOCKS_RESET      = LEN_W'(1024);

  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY      = 3'd0,
    MODE_ALLOC      = 3'd1,
    MODE_FREE_ONE   = 3'd2,
    MODE_FREE_RANGE = 3'd3,
    MODE_FIND       = 3'd4
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NORUN = 2'd2
  } status_t;

  // Byte of the map after reset: blocks 0 and 1 are reserved.
  function automatic logic [7:0] reset_byte(input logic [BYTE_W-1:0] addr);
    logic [7:0] val;
    val = 8'hFF;
    if (addr == '0) begin
      val = 8'hFC;
    end
    return val;
  endfunction

endpackage

FILE: src/block_bitmap_allocator_top.sv
// Query, allocate and free-one pass through a read step and a modify step; an index out
// of range or an unknown mode goes straight to the done step; free-range reads and modifies
// each map byte touched in turn; find-run walks the map one byte per cycle, over ceil(limit/8)
// bytes at most, stopping early at the first run found. One request at a time: the next
// transaction is taken in the cycle the result becomes valid at the earliest. Reset: synchronous,
// active high; blocks_in_use goes to 1024 and every map byte reads as free except blocks 0 and 1.
module block_bitmap_allocator_top (
  input  logic                              clk,
  input  logic                              rst,
  // slave side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bba_pkg::IN_W-1:0]          s_tdata,   // mode[2:0], blk_idx[12:3], run_length[23:13]
  // master side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bba_pkg::OUT_W-1:0]         m_tdata,   // is_free[0], run_start[10:1], status[12:11]
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bba_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_MOD  = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  localparam int BYTE_W  = bba_pkg::BYTE_W;
  localparam int NBYTE_W = bba_pkg::NBYTE_W;
  localparam int BLK_W   = bba_pkg::BLK_W;
  localparam int LEN_W   = bba_pkg::LEN_W;

  state_t                   state;
  bba_pkg::mode_t           op;
  bba_pkg::status_t         res_st;
  logic                     res_free;
  logic [BLK_W-1:0]         res_start;
  logic [BLK_W-1:0]         idx;
  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         end_blk;
  logic [LEN_W-1:0]         lim;
  logic [BYTE_W-1:0]        cur;
  logic [LEN_W-1:0]         blocks_in_use;

  // run search
  logic [NBYTE_W-1:0]       iss;
  logic [NBYTE_W-1:0]       nbytes;
  logic                     pend;
  logic [LEN_W-1:0]         cnt;

  // map storage
  logic [bba_pkg::MAP_BYTES-1:0] vld;
  logic [BYTE_W-1:0]        rd_addr;
  logic [BYTE_W-1:0]        ram_raddr;
  logic                     ram_we;
  logic [7:0]               ram_wdata;
  logic [7:0]               ram_rdata;
  logic [7:0]               eff;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr == bba_pkg::REG_BLOCKS_IN_USE) begin
      prdata = 32'(blocks_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= bba_pkg::BLOCKS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == bba_pkg::REG_BLOCKS_IN_USE) begin
      blocks_in_use <= pwdata[LEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic [bba_pkg::MODE_W-1:0] in_mode;
  logic [BLK_W-1:0]           in_idx;
  logic [LEN_W-1:0]           in_len;
  logic [LEN_W-1:0]           lim_c;
  logic                       in_range;
  logic [LEN_W:0]             in_sum;
  logic                       sum_over;

  assign in_mode  = s_tdata[2:0];
  assign in_idx   = s_tdata[12:3];
  assign in_len   = s_tdata[23:13];
  // clip the managed count to the map size
  assign lim_c    = (blocks_in_use > LEN_W'(bba_pkg::MAX_BLOCKS)) ?
                    LEN_W'(bba_pkg::MAX_BLOCKS) : blocks_in_use;
  assign in_range = LEN_W'(in_idx) < lim_c;
  assign in_sum   = (LEN_W + 1)'(in_idx) + (LEN_W + 1)'(in_len);
  assign sum_over = in_sum > (LEN_W + 1)'(lim_c);

  assign s_tready = (state == S_IDLE);

  // ---------------------------------------------------------------------------
  // Map RAM: one read and one write port, byte per entry. A byte never written
  // since reset takes its reset value from the valid bit.
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_raddr = cur;
    if (state == S_SCAN) begin
      ram_raddr = iss[BYTE_W-1:0];
    end
  end

  assign eff = vld[rd_addr] ? ram_rdata : bba_pkg::reset_byte(rd_addr);

  // masks for the read-modify-write paths
  logic [7:0] bmask;
  logic [7:0] fmask;
  logic [LEN_W-1:0] fblk;

  assign bmask = 8'(1) << idx[2:0];

  always_comb begin
    fmask = '0;
    fblk  = '0;
    for (int j = 0; j < 8; j++) begin
      fblk     = LEN_W'({rd_addr, 3'(j)});
      fmask[j] = (fblk >= LEN_W'(idx)) && (fblk < end_blk);
    end
  end

  always_comb begin
    ram_wdata = eff;
    unique case (op)
      bba_pkg::MODE_ALLOC:      ram_wdata = eff & ~bmask;
      bba_pkg::MODE_FREE_ONE:   ram_wdata = eff | bmask;
      bba_pkg::MODE_FREE_RANGE: ram_wdata = eff | fmask;
      default:                  ram_wdata = eff;
    endcase
  end

  assign ram_we = (state == S_MOD) && (op != bba_pkg::MODE_QUERY);

  bba_ram #(
    .WIDTH (8),
    .DEPTH (bba_pkg::MAP_BYTES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Run search: one map byte per cycle, the free count carried bit by bit
  // across the byte. Stop at the first bit where the count reaches the length.
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] scan_cnt;
  logic             scan_hit;
  logic [LEN_W-1:0] scan_pos;
  logic [LEN_W-1:0] sblk;

  always_comb begin
    scan_cnt = cnt;
    scan_hit = 1'b0;
    scan_pos = '0;
    sblk     = '0;
    for (int j = 0; j < 8; j++) begin
      sblk = LEN_W'({rd_addr, 3'(j)});
      if (!scan_hit && sblk < lim) begin
        if (eff[j]) begin
          scan_cnt = scan_cnt + LEN_W'(1);
          if (scan_cnt == len) begin
            scan_hit = 1'b1;
            scan_pos = sblk;
          end
        end else begin
          scan_cnt = '0;
        end
      end
    end
  end

  logic [LEN_W-1:0] run_first;
  logic [BYTE_W-1:0] last_byte;
  logic [LEN_W-1:0]  end_m1;

  assign run_first = scan_pos + LEN_W'(1) - len;
  assign end_m1    = end_blk - LEN_W'(1);
  assign last_byte = end_m1[BLK_W-1:3];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    rd_addr <= ram_raddr;
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      vld      <= '0;
    end else begin
      // raise the result in the done step once the output register is free;
      // drop it once taken
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ram_we) begin
        vld[rd_addr] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op        <= bba_pkg::mode_t'(in_mode);
            idx       <= in_idx;
            len       <= in_len;
            lim       <= lim_c;
            cur       <= in_idx[BLK_W-1:3];
            res_free  <= 1'b0;
            res_start <= '0;
            res_st    <= bba_pkg::ST_OK;
            unique case (in_mode)
              bba_pkg::MODE_QUERY, bba_pkg::MODE_ALLOC, bba_pkg::MODE_FREE_ONE: begin
                if (in_range) begin
                  state <= S_RD;
                end else begin
                  res_st <= bba_pkg::ST_RANGE;
                  state  <= S_DONE;
                end
              end
              bba_pkg::MODE_FREE_RANGE: begin
                if (!in_range) begin
                  res_st <= bba_pkg::ST_RANGE;
                  state  <= S_DONE;
                end else if (in_len == '0) begin
                  state <= S_DONE;
                end else begin
                  // clip the range at the limit and flag it
                  end_blk <= sum_over ? lim_c : in_sum[LEN_W-1:0];
                  res_st  <= sum_over ? bba_pkg::ST_RANGE : bba_pkg::ST_OK;
                  state   <= S_RD;
                end
              end
              bba_pkg::MODE_FIND: begin
                iss    <= '0;
                pend   <= 1'b0;
                cnt    <= '0;
                nbytes <= NBYTE_W'((lim_c + LEN_W'(7)) >> 3);
                state  <= S_SCAN;
              end
              default: begin
                res_st <= bba_pkg::ST_RANGE;
                state  <= S_DONE;
              end
            endcase
          end
        end

        S_RD: begin
          state <= S_MOD;
        end

        S_MOD: begin
          if (op == bba_pkg::MODE_QUERY) begin
            res_free <= eff[idx[2:0]];
          end
          if (op == bba_pkg::MODE_FREE_RANGE && cur != last_byte) begin
            cur   <= cur + BYTE_W'(1);
            state <= S_RD;
          end else begin
            state <= S_DONE;
          end
        end

        S_SCAN: begin
          priority if (pend && scan_hit) begin
            res_start <= run_first[BLK_W-1:0];
            state     <= S_DONE;
          end else if (!pend && iss >= nbytes) begin
            res_st <= bba_pkg::ST_NORUN;
            state  <= S_DONE;
          end else begin
            if (pend) begin
              cnt <= scan_cnt;
            end
            pend <= (iss < nbytes);
            if (iss < nbytes) begin
              iss <= iss + NBYTE_W'(1);
            end
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata <= {3'b000, res_st, res_start, res_free};
            state   <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a request is in progress");

  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !ram_we)
    else $error("map written during a run search");

  a_norun_only_find: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_st == bba_pkg::ST_NORUN) |-> (op == bba_pkg::MODE_FIND))
    else $error("no-run status outside find mode");

  a_free_only_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_free) |-> (op == bba_pkg::MODE_QUERY && res_st == bba_pkg::ST_OK))
    else $error("is_free set outside a successful query");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside the done step");

endmodule

FILE: src/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: verif/tb_block_bitmap_allocator_top.sv
`timescale 1ns / 1ps

module tb_block_bitmap_allocator_top;
  import bba_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  // Longest legal quiet stretch: the receiver hold-off plus a full-map free-range sweep.
  localparam int STALL_LIMIT  = 3000;
  // Free-range over all 128 map bytes is the slowest request.
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 320;
  localparam int PHASE_ITEMS  = 90;
  localparam int NUM_PHASES   = 10;

  // Mode codes the block does not implement; they must come back flagged.
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic             is_free;
    logic [BLK_W-1:0] run_start;
    status_t          status;
  } alloc_result_t;

  // Shadow of the free map and the block count. Every accepted request is
  // applied here in acceptance order and yields the one result it must produce.
  class free_map_tracker;
    bit               free_map [MAX_BLOCKS];
    logic [LEN_W-1:0] blocks_in_use;
    alloc_result_t    expected_results [$];
    int unsigned      results_seen;
    int               errors;

    function new();
      foreach (free_map[b]) free_map[b] = 1'b1;
      free_map[0]   = 1'b0;
      free_map[1]   = 1'b0;
      blocks_in_use = BLOCKS_RESET;
      results_seen  = 0;
      errors        = 0;
    endfunction

    function int unsigned limit();
      return (blocks_in_use > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_in_use);
    endfunction

    function void note_request(logic [IN_W-1:0] item);
      logic [MODE_W-1:0] mode;
      logic [BLK_W-1:0]  idx;
      logic [LEN_W-1:0]  len;
      int unsigned       lim;
      int unsigned       stop;
      int unsigned       count;
      bit                found;
      alloc_result_t     r;
      mode        = item[MODE_W-1:0];
      idx         = item[MODE_W +: BLK_W];
      len         = item[MODE_W+BLK_W +: LEN_W];
      lim         = limit();
      r.is_free   = 1'b0;
      r.run_start = '0;
      r.status    = ST_OK;
      case (mode)
        MODE_QUERY: begin
          if (idx < lim) r.is_free = free_map[idx];
          else r.status = ST_RANGE;
        end
        MODE_ALLOC, MODE_FREE_ONE: begin
          if (idx < lim) free_map[idx] = (mode == MODE_FREE_ONE);
          else r.status = ST_RANGE;
        end
        MODE_FREE_RANGE: begin
          if (idx >= lim) begin
            r.status = ST_RANGE;
          end else begin
            stop = idx + len;
            if (stop > lim) begin
              stop     = lim;
              r.status = ST_RANGE;
            end
            for (int unsigned b = idx; b < stop; b++) free_map[b] = 1'b1;
          end
        end
        MODE_FIND: begin
          // First fit: count consecutive free blocks, restart on each used one.
          count = 0;
          found = 1'b0;
          for (int unsigned b = 0; b < lim && !found; b++) begin
            if (free_map[b]) begin
              count++;
              if (count == len) begin
                r.run_start = BLK_W'(b + 1 - len);
                found       = 1'b1;
              end
            end else begin
              count = 0;
            end
          end
          if (!found) r.status = ST_NORUN;
        end
        default: r.status = ST_RANGE;
      endcase
      expected_results.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH %s", $time, what);
      errors++;
    endtask

    task check_result(logic [OUT_W-1:0] word);
      alloc_result_t got;
      alloc_result_t want;
      got.is_free   = word[0];
      got.run_start = word[BLK_W:1];
      got.status    = status_t'(word[BLK_W+1 +: STAT_W]);
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", results_seen));
      end else begin
        want = expected_results.pop_front();
        if (got.is_free !== want.is_free)
          report($sformatf("result %0d is_free got %0d expected %0d",
                           results_seen, got.is_free, want.is_free));
        if (got.run_start !== want.run_start)
          report($sformatf("result %0d run_start got %0d expected %0d",
                           results_seen, got.run_start, want.run_start));
        if (got.status !== want.status)
          report($sformatf("result %0d status got %0d expected %0d",
                           results_seen, got.status, want.status));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;   // mode[2:0], blk_idx[12:3], run_length[23:13]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;        // is_free[0], run_start[10:1], status[12:11]
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  free_map_tracker tracker;
  bit              idling_on = 1'b1;
  bit              hold_off_req = 1'b0;
  int              quiet_cycles = 0;

  block_bitmap_allocator_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Monitor both streams at the clock edge. Note the request before checking
  // the result so that the shadow map always reflects acceptance order.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.note_request(s_tdata);
      if (m_tvalid && m_tready) tracker.check_result(m_tdata);
    end
  end

  // Watchdog: any transaction on either stream or the register port resets it.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("block_bitmap_allocator_top regression: fail");
        $finish;
      end
    end
  end

  // Result receiver: random ready stretches, random stall bursts, and one long
  // hold-off on request so that the block backs up and stalls its input.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idling_on && $urandom_range(3, 0) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(14, 1)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(24, 1)) @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until accepted; then maybe go quiet for a
  // burst. Keep tvalid high into the next call when there is no gap.
  task automatic send_request(logic [MODE_W-1:0] mode, logic [BLK_W-1:0] idx,
                              logic [LEN_W-1:0] len);
    s_tdata  <= {len, idx, mode};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (idling_on && $urandom_range(3, 0) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
  endtask

  // Drop tvalid and wait until every outstanding request has produced its
  // result. Wait for a clock edge before checking so the monitor has noted the last request.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.expected_results.size() != 0);
  endtask

  // Write the block count with the block idle, then read it back.
  task automatic set_blocks_in_use(logic [LEN_W-1:0] count);
    wait_for_results();
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_BLOCKS_IN_USE;
    pwdata  <= 32'(count);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.blocks_in_use = count;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(count))
      tracker.report($sformatf("blocks_in_use readback got %0d expected %0d", prdata, count));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random request mix. Allocation dominates so the map fragments and runs
  // get hard to find; most indexes land inside the managed blocks, with a
  // bias toward the low blocks so that region fills up on large maps.
  task automatic random_request();
    int unsigned       lim;
    int unsigned       pick;
    int unsigned       flavor;
    logic [MODE_W-1:0] mode;
    logic [BLK_W-1:0]  idx;
    logic [LEN_W-1:0]  len;
    lim    = tracker.limit();
    pick   = $urandom_range(99, 0);
    flavor = $urandom_range(19, 0);
    len    = $urandom_range(2047, 0);
    if (lim != 0 && $urandom_range(99, 0) < 85) begin
      if (lim > 64 && $urandom_range(1, 0) == 0) idx = $urandom_range(63, 0);
      else idx = $urandom_range(lim - 1, 0);
    end else begin
      idx = $urandom_range(MAX_BLOCKS - 1, 0);
    end
    if (pick < 12) begin
      mode = MODE_QUERY;
    end else if (pick < 45) begin
      mode = MODE_ALLOC;
    end else if (pick < 57) begin
      mode = MODE_FREE_ONE;
    end else if (pick < 65) begin
      // Mostly short ranges; now and then one that runs past the limit.
      mode = MODE_FREE_RANGE;
      if (flavor < 14) len = $urandom_range(16, 0);
      else if (flavor < 18) len = $urandom_range(200, 0);
    end else if (pick < 93) begin
      mode = MODE_FIND;
      if (flavor < 10) len = $urandom_range(8, 1);
      else if (flavor < 16) len = $urandom_range(64, 1);
      else if (flavor < 18) len = $urandom_range(MAX_BLOCKS, 1);
      else if (flavor == 18) len = '0;
      else len = $urandom_range(2047, MAX_BLOCKS);
    end else begin
      mode = $urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST);
    end
    send_request(mode, idx, len);
  endtask

  // Block counts per phase: zero, one, the full map, counts above the map
  // (clipped), and odd sizes in between. Reset value 1024 covers the start.
  logic [LEN_W-1:0] phase_blocks [NUM_PHASES] = '{
    11'd48, 11'd0, 11'd2047, 11'd1, 11'd300, 11'd1025, 11'd16, 11'd700, 11'd1023, 11'd1024
  };

  initial begin
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reserved blocks, first-fit search edges, clipped and empty
    // ranges, and the unused mode codes, all on the full reset map.
    send_request(MODE_QUERY, 10'd0, 11'd0);
    send_request(MODE_QUERY, 10'd1, 11'd0);
    send_request(MODE_QUERY, 10'd1023, 11'd0);
    send_request(MODE_FIND, 10'd0, 11'd1);
    send_request(MODE_FIND, 10'd0, 11'd0);
    send_request(MODE_FIND, 10'd0, 11'd1022);
    send_request(MODE_FIND, 10'd0, 11'd1023);
    send_request(MODE_FIND, 10'd1023, 11'd2047);
    send_request(MODE_ALLOC, 10'd1023, 11'd0);
    send_request(MODE_QUERY, 10'd1023, 11'd0);
    send_request(MODE_ALLOC, 10'd2, 11'd0);
    send_request(MODE_ALLOC, 10'd5, 11'd0);
    send_request(MODE_FIND, 10'd0, 11'd3);
    send_request(MODE_FREE_ONE, 10'd5, 11'd0);
    send_request(MODE_FREE_RANGE, 10'd0, 11'd0);
    send_request(MODE_FREE_RANGE, 10'd1020, 11'd10);
    send_request(MODE_ALLOC, 10'd0, 11'd0);
    send_request(MODE_FREE_RANGE, 10'd0, 11'd2);
    send_request(MODE_QUERY, 10'd0, 11'd0);
    send_request(MODE_SPARE_FIRST, 10'd1023, 11'd2047);
    send_request(3'(MODE_SPARE_FIRST + 1), 10'd0, 11'd0);
    send_request(MODE_SPARE_LAST, 10'd512, 11'd1024);
    send_request(MODE_FIND, 10'd0, 11'd1024);

    // Random phases, one block count each. Go quiet in the last phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_blocks_in_use(phase_blocks[p]);
      if (p == NUM_PHASES - 1) idling_on = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 30) hold_off_req = 1'b1;
        random_request();
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.expected_results.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.expected_results.size()));
    if (tracker.errors == 0) begin
      $display("block_bitmap_allocator_top regression: pass");
    end else begin
      $display("block_bitmap_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
